// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hdl/cswp_pkg.sv -----
package cswp_pkg;

	// pool geometry
	localparam int FRAMES  = 16;
	localparam int FRAME_W = $clog2(FRAMES);
	localparam int CNT_W   = FRAME_W + 1;

	// fixed field widths
	localparam int CFG_W   = 5;
	localparam int PAGE_W  = 31;
	localparam int PIN_W   = 8;
	localparam int FOUT_W  = 4;
	localparam int STS_W   = 3;

	localparam logic [PIN_W-1:0] PIN_MAX = 8'd255;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// request kinds
	localparam logic ACT_FETCH = 1'b0;
	localparam logic ACT_UNPIN = 1'b1;

	// result codes
	typedef enum logic [STS_W-1:0] {
		STS_HIT        = 3'd0,
		STS_LOADED     = 3'd1,
		STS_EVICTED    = 3'd2,
		STS_ALL_PINNED = 3'd3,
		STS_UNPINNED   = 3'd4,
		STS_UNPIN_MISS = 3'd5
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWEEP,
		ST_EMIT
	} state_t;

endpackage

// ----- hdl/cswp_req_if.sv -----
interface cswp_req_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [cswp_pkg::PAGE_W-1:0] page_id;
	logic                        mark_dirty;

	modport source (output valid, output action, output page_id, output mark_dirty,
		input ready);
	modport sink (input valid, input action, input page_id, input mark_dirty,
		output ready);
endinterface

// ----- hdl/cswp_rsp_if.sv -----
interface cswp_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [cswp_pkg::STS_W-1:0]  status;
	logic [cswp_pkg::FOUT_W-1:0] frame;
	logic [cswp_pkg::PAGE_W-1:0] evicted_page;
	logic                        write_back;
	logic [cswp_pkg::PIN_W-1:0]  pins_left;

	modport source (output valid, output status, output frame, output evicted_page,
		output write_back, output pins_left, input ready);
	modport sink (input valid, input status, input frame, input evicted_page,
		input write_back, input pins_left, output ready);
endinterface

// ----- hdl/clock_sweep_buffer_pool_core.sv -----
// Buffer-frame pool with clock (second-chance) replacement and pin counts.
// req carries one item per request: action (fetch or unpin), page_id and
// mark_dirty. rsp returns exactly one item per request: status, frame,
// evicted_page, write_back and pins_left. Both are valid/ready channels.
// cfg_we/cfg_wdata write frames_in_use; write it only while the pool is idle.
// One compare unit walks the frame table one frame per cycle. A lookup
// visits frames 0 up to the hit, or all 16 on a miss; a fetch miss with no
// empty frame but an unpinned frame in the span then sweeps the hand, at
// most 2*frames_in_use frames. The held result then moves into the output
// register once that is free. Only one request is in work at a time, and
// req.ready is high when idle.
// A result waiting on a stalled receiver does not block the next accept,
// but a second result waits until the first is taken.
// Reset empties all frames, clears pins and marks, sets the hand to frame 0
// and frames_in_use to 16.
module clock_sweep_buffer_pool_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cswp_pkg::CFG_W-1:0]  cfg_wdata,
	cswp_req_if.sink                    req,
	cswp_rsp_if.source                  rsp
);

	localparam int FW = cswp_pkg::FRAME_W;
	localparam int CW = cswp_pkg::CNT_W;
	localparam int PW = cswp_pkg::PAGE_W;
	localparam int NW = cswp_pkg::PIN_W;
	localparam logic [FW-1:0] LAST_IDX = FW'(cswp_pkg::FRAMES - 1);

	cswp_pkg::state_t state_q, state_d;

	// frame table
	logic          valid_q [cswp_pkg::FRAMES];
	logic [PW-1:0] page_q  [cswp_pkg::FRAMES];
	logic [NW-1:0] pins_q  [cswp_pkg::FRAMES];
	logic          ref_q   [cswp_pkg::FRAMES];
	logic          dirty_q [cswp_pkg::FRAMES];

	logic [cswp_pkg::CFG_W-1:0] cfg_q;
	logic [FW-1:0] hand_q;
	logic [FW-1:0] idx_q;
	logic [FW-1:0] h_q;
	logic          empty_q;
	logic [FW-1:0] empty_idx_q;
	logic          free_q;

	// captured request
	logic          act_q;
	logic [PW-1:0] pid_q;
	logic          md_q;

	// held result
	cswp_pkg::status_t res_status_q;
	logic [FW-1:0] res_frame_q;
	logic [PW-1:0] res_ev_q;
	logic          res_wb_q;
	logic [NW-1:0] res_pins_q;

	// output register
	logic          rsp_valid_q;
	logic [cswp_pkg::STS_W-1:0]  rsp_status_q;
	logic [cswp_pkg::FOUT_W-1:0] rsp_frame_q;
	logic [PW-1:0] rsp_ev_q;
	logic          rsp_wb_q;
	logic [NW-1:0] rsp_pins_q;

	// active span of the pool, clamped to 1..FRAMES
	logic [CW-1:0] span;
	always_comb begin
		if (cfg_q == '0)
			span = CW'(1);
		else if (int'(cfg_q) > cswp_pkg::FRAMES)
			span = CW'(cswp_pkg::FRAMES);
		else
			span = CW'(cfg_q);
	end

	// the frame under the compare unit this cycle
	logic [FW-1:0] addr;
	logic          cur_valid;
	logic [PW-1:0] cur_page;
	logic [NW-1:0] cur_pins;
	logic          cur_ref;
	logic          cur_dirty;
	logic          in_span;
	assign addr      = (state_q == cswp_pkg::ST_SWEEP) ? h_q : idx_q;
	assign cur_valid = valid_q[addr];
	assign cur_page  = page_q[addr];
	assign cur_pins  = pins_q[addr];
	assign cur_ref   = ref_q[addr];
	assign cur_dirty = dirty_q[addr];
	assign in_span   = {1'b0, addr} < span;

	// scan and sweep conditions
	logic          hit;
	logic          last;
	logic          empty_now;
	logic [FW-1:0] empty_at;
	logic          free_now;
	logic          victim;
	logic          clear_ref;
	logic [FW-1:0] h_next;
	logic [FW-1:0] hand_start;
	logic          rsp_free;
	assign hit        = (state_q == cswp_pkg::ST_SCAN) && cur_valid && (cur_page == pid_q);
	assign last       = idx_q == LAST_IDX;
	assign empty_now  = empty_q | (in_span & ~cur_valid);
	assign empty_at   = empty_q ? empty_idx_q : addr;
	assign free_now   = free_q | (in_span & (cur_pins == '0));
	assign victim     = (state_q == cswp_pkg::ST_SWEEP) && (cur_pins == '0) && !cur_ref;
	assign clear_ref  = (state_q == cswp_pkg::ST_SWEEP) && (cur_pins == '0) && cur_ref;
	assign h_next     = (({1'b0, h_q} + CW'(1)) == span) ? '0 : h_q + FW'(1);
	assign hand_start = ({1'b0, hand_q} >= span) ? '0 : hand_q;
	assign rsp_free   = !rsp_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cswp_pkg::ST_IDLE: begin
				if (req.valid)
					state_d = cswp_pkg::ST_SCAN;
			end
			cswp_pkg::ST_SCAN: begin
				if (hit)
					state_d = cswp_pkg::ST_EMIT;
				else if (last) begin
					if (act_q == cswp_pkg::ACT_FETCH && !empty_now && free_now)
						state_d = cswp_pkg::ST_SWEEP;
					else
						state_d = cswp_pkg::ST_EMIT;
				end
			end
			cswp_pkg::ST_SWEEP: begin
				if (victim)
					state_d = cswp_pkg::ST_EMIT;
			end
			cswp_pkg::ST_EMIT: begin
				if (rsp_free)
					state_d = cswp_pkg::ST_IDLE;
			end
			default: state_d = cswp_pkg::ST_IDLE;
		endcase
	end

	// table write and result selection
	logic          we;
	logic [FW-1:0] wa;
	logic          w_load;
	logic [NW-1:0] w_pins;
	logic          w_ref;
	logic          w_dirty;
	logic          res_we;
	cswp_pkg::status_t res_status;
	logic [FW-1:0] res_frame;
	logic [PW-1:0] res_ev;
	logic          res_wb;
	logic [NW-1:0] res_pins;
	always_comb begin
		we         = 1'b0;
		wa         = addr;
		w_load     = 1'b0;
		w_pins     = cur_pins;
		w_ref      = cur_ref;
		w_dirty    = cur_dirty;
		res_we     = 1'b0;
		res_status = cswp_pkg::STS_HIT;
		res_frame  = '0;
		res_ev     = '0;
		res_wb     = 1'b0;
		res_pins   = '0;
		unique case (state_q)
			cswp_pkg::ST_SCAN: begin
				if (hit) begin
					we        = 1'b1;
					res_we    = 1'b1;
					res_frame = addr;
					if (act_q == cswp_pkg::ACT_UNPIN) begin
						w_pins     = (cur_pins != '0) ? cur_pins - NW'(1) : cur_pins;
						w_dirty    = cur_dirty | md_q;
						res_status = cswp_pkg::STS_UNPINNED;
					end else begin
						w_pins     = (cur_pins < cswp_pkg::PIN_MAX) ? cur_pins + NW'(1)
							: cur_pins;
						w_ref      = 1'b1;
						res_status = cswp_pkg::STS_HIT;
					end
					res_pins = w_pins;
				end else if (last) begin
					if (act_q == cswp_pkg::ACT_UNPIN) begin
						res_we     = 1'b1;
						res_status = cswp_pkg::STS_UNPIN_MISS;
					end else if (empty_now) begin
						we         = 1'b1;
						wa         = empty_at;
						w_load     = 1'b1;
						res_we     = 1'b1;
						res_status = cswp_pkg::STS_LOADED;
						res_frame  = empty_at;
						res_pins   = NW'(1);
					end else if (!free_now) begin
						res_we     = 1'b1;
						res_status = cswp_pkg::STS_ALL_PINNED;
					end
				end
			end
			cswp_pkg::ST_SWEEP: begin
				if (victim) begin
					we         = 1'b1;
					w_load     = 1'b1;
					res_we     = 1'b1;
					res_status = cswp_pkg::STS_EVICTED;
					res_frame  = addr;
					res_ev     = cur_page;
					res_wb     = cur_dirty;
					res_pins   = NW'(1);
				end else if (clear_ref) begin
					we    = 1'b1;
					w_ref = 1'b0;
				end
			end
			cswp_pkg::ST_IDLE, cswp_pkg::ST_EMIT: begin
				we = 1'b0;
			end
			default: we = 1'b0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cswp_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_q <= cswp_pkg::CFG_RESET;
		else if (cfg_we)
			cfg_q <= cfg_wdata;
	end

	// frame status bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cswp_pkg::FRAMES; i++) begin
				valid_q[i] <= 1'b0;
				pins_q[i]  <= '0;
				ref_q[i]   <= 1'b0;
				dirty_q[i] <= 1'b0;
			end
		end else if (we) begin
			if (w_load) begin
				valid_q[wa] <= 1'b1;
				pins_q[wa]  <= NW'(1);
				ref_q[wa]   <= 1'b1;
				dirty_q[wa] <= 1'b0;
			end else begin
				pins_q[wa]  <= w_pins;
				ref_q[wa]   <= w_ref;
				dirty_q[wa] <= w_dirty;
			end
		end
	end

	// page numbers, written on load only
	always_ff @(posedge clk) begin
		if (we && w_load)
			page_q[wa] <= pid_q;
	end

	// scan index, sweep position and hand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			h_q         <= '0;
			hand_q      <= '0;
			empty_q     <= 1'b0;
			empty_idx_q <= '0;
			free_q      <= 1'b0;
		end else begin
			unique case (state_q)
				cswp_pkg::ST_IDLE: begin
					idx_q   <= '0;
					empty_q <= 1'b0;
					free_q  <= 1'b0;
				end
				cswp_pkg::ST_SCAN: begin
					idx_q       <= idx_q + FW'(1);
					empty_q     <= empty_now;
					empty_idx_q <= empty_at;
					free_q      <= free_now;
					h_q         <= hand_start;
				end
				cswp_pkg::ST_SWEEP: begin
					h_q <= h_next;
					if (victim)
						hand_q <= h_next;
				end
				cswp_pkg::ST_EMIT: begin
					idx_q <= '0;
				end
				default: idx_q <= '0;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (state_q == cswp_pkg::ST_IDLE && req.valid) begin
			act_q <= req.action;
			pid_q <= req.page_id;
			md_q  <= req.mark_dirty;
		end
	end

	// result hold
	always_ff @(posedge clk) begin
		if (res_we) begin
			res_status_q <= res_status;
			res_frame_q  <= res_frame;
			res_ev_q     <= res_ev;
			res_wb_q     <= res_wb;
			res_pins_q   <= res_pins;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (state_q == cswp_pkg::ST_EMIT && rsp_free)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == cswp_pkg::ST_EMIT && rsp_free) begin
			rsp_status_q <= res_status_q;
			rsp_frame_q  <= cswp_pkg::FOUT_W'(res_frame_q);
			rsp_ev_q     <= res_ev_q;
			rsp_wb_q     <= res_wb_q;
			rsp_pins_q   <= res_pins_q;
		end
	end

	// channel ports
	assign req.ready        = state_q == cswp_pkg::ST_IDLE;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.frame        = rsp_frame_q;
	assign rsp.evicted_page = rsp_ev_q;
	assign rsp.write_back   = rsp_wb_q;
	assign rsp.pins_left    = rsp_pins_q;

endmodule

// ----- hdl/cswp_checker.sv -----
`include "assert_macros.svh"

module cswp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [cswp_pkg::STS_W-1:0]  rsp_status,
	input logic [cswp_pkg::FOUT_W-1:0] rsp_frame,
	input logic [cswp_pkg::PAGE_W-1:0] rsp_evicted_page,
	input logic                        rsp_write_back,
	input logic [cswp_pkg::PIN_W-1:0]  rsp_pins_left
);

	logic no_frame;
	logic loaded;
	assign no_frame = rsp_status == cswp_pkg::STS_ALL_PINNED
		|| rsp_status == cswp_pkg::STS_UNPIN_MISS;
	assign loaded = rsp_status == cswp_pkg::STS_LOADED
		|| rsp_status == cswp_pkg::STS_EVICTED;

	// one request in work at a time
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready, "ready after accept")

	// a stalled result holds
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_frame) && $stable(rsp_pins_left), "stalled result changed")

	// no frame and no pins when nothing was found
	`ASSERT_IMPLY(a_no_frame_zero, clk, arst_n, rsp_valid && no_frame, rsp_frame == '0 && rsp_pins_left == '0, "frame or pins on empty result")

	// eviction fields only on eviction
	`ASSERT_IMPLY(a_evict_only, clk, arst_n, rsp_valid && rsp_status != cswp_pkg::STS_EVICTED, rsp_evicted_page == '0 && !rsp_write_back, "eviction fields without eviction")

	// a freshly loaded page holds one pin
	`ASSERT_IMPLY(a_load_one_pin, clk, arst_n, rsp_valid && loaded, rsp_pins_left == cswp_pkg::PIN_W'(1), "loaded page pin count")

endmodule

bind clock_sweep_buffer_pool_core cswp_checker u_cswp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_frame        (rsp.frame),
	.rsp_evicted_page (rsp.evicted_page),
	.rsp_write_back   (rsp.write_back),
	.rsp_pins_left    (rsp.pins_left)
);
